// File: rtl/core/plf_pkg.sv
// Shared types, constants and the square-root step function for the pipe leak flow block.
// Used by every module under rtl/core; depends on nothing else.
package plf_pkg;

	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QAW       = 2;
	localparam int unsigned QCW       = 3;
	localparam int unsigned SQ_STAGES = 22;

	// Square feet per square metre scaled to Q.24, and the orifice
	// coefficient divided by 100 and by 2 in Q.52.
	localparam logic [27:0] KA  = 28'd180588450;
	localparam logic [26:0] KC  = 27'd108423859;
	localparam logic [47:0] CAP = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic        j1;
		logic        j2;
		logic        zero;
		logic [31:0] h1;
		logic [31:0] h2;
		logic [31:0] area;
		logic [31:0] expan;
		logic [31:0] len;
	} plf_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} plf_qstat_t;

	typedef struct packed {
		logic [23:0] rem;
		logic [21:0] root;
	} plf_sqrt_t;

	// One digit of the restoring square root: brings in two radicand bits.
	function automatic plf_sqrt_t sqrt_step(plf_sqrt_t cur, logic [1:0] d);
		logic [25:0] rr;
		logic [25:0] trial;
		plf_sqrt_t   nxt;
		rr    = {cur.rem, d};
		trial = {2'b00, cur.root, 2'b01};
		if (rr >= trial) begin
			nxt.rem  = 24'(rr - trial);
			nxt.root = {cur.root[20:0], 1'b1};
		end else begin
			nxt.rem  = rr[23:0];
			nxt.root = {cur.root[20:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// File: rtl/core/plf_front.sv
// Front end: accepts items, works out the clamped pressure heads and the kill flag.
// Depends on plf_pkg.
module plf_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               is_pipe,
	input  logic               end1_is_junction,
	input  logic               end2_is_junction,
	input  logic signed [31:0] head_start,
	input  logic signed [31:0] elev_start,
	input  logic signed [31:0] head_end,
	input  logic signed [31:0] elev_end,
	input  logic        [31:0] leak_area,
	input  logic        [31:0] leak_expansion,
	input  logic        [31:0] pipe_length,
	input  plf_pkg::plf_qstat_t qstat,
	output logic               push,
	output plf_pkg::plf_entry_t entry
);

	logic signed [32:0] d1;
	logic signed [32:0] d2;

	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;

	assign d1 = 33'(head_start) - 33'(elev_start);
	assign d2 = 33'(head_end) - 33'(elev_end);

	always_comb begin
		entry.j1    = end1_is_junction;
		entry.j2    = end2_is_junction;
		entry.zero  = !is_pipe || (leak_area == '0 && leak_expansion == '0)
			|| (!end1_is_junction && !end2_is_junction);
		entry.h1    = (d1 > 0) ? d1[31:0] : '0;
		entry.h2    = (d2 > 0) ? d2[31:0] : '0;
		entry.area  = leak_area;
		entry.expan = leak_expansion;
		entry.len   = pipe_length;
	end

endmodule

// File: rtl/core/plf_queue.sv
// Short item queue between the front end and the arithmetic back end.
// Depends on plf_pkg.
module plf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  plf_pkg::plf_entry_t entry_in,
	input  logic                pop,
	output plf_pkg::plf_entry_t entry_out,
	output plf_pkg::plf_qstat_t qstat
);

	plf_pkg::plf_entry_t                mem_q [plf_pkg::QDEPTH];
	logic [plf_pkg::QAW-1:0]            wptr_q;
	logic [plf_pkg::QAW-1:0]            rptr_q;
	logic [plf_pkg::QCW-1:0]            cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign entry_out   = mem_q[rptr_q];
	assign qstat.full  = (cnt_q == plf_pkg::QCW'(plf_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);

endmodule

// File: rtl/core/plf_back.sv
// Back end: square-root digit pipeline for both ends, leak-area products and the
// final scaling, doubling and saturation. Depends on plf_pkg.
module plf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         luf,
	input  plf_pkg::plf_qstat_t qstat,
	input  plf_pkg::plf_entry_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [47:0]         leak_flow
);

	typedef struct packed {
		logic j1;
		logic j2;
		logic zero;
	} flags_t;

	typedef struct packed {
		flags_t          fl;
		logic [1:0][31:0] h;
		logic [31:0]     area;
		logic [31:0]     expan;
		logic [31:0]     len;
		logic [59:0]     aq_p;
		logic [1:0][63:0] mh_p;
		logic [63:0]     lu_p;
		logic [35:0]     aq;
		logic [1:0][51:0] mh;
		logic [33:0]     lu;
		logic [1:0][52:0] w;
		logic [60:0]     c_p;
		logic [44:0]     c;
	} side_t;

	// The non-root arithmetic rides along the first few root stages.
	function automatic side_t side_step(side_t s, int k, logic [31:0] f);
		side_t       r;
		logic [60:0] ta;
		logic [64:0] tm0;
		logic [64:0] tm1;
		logic [64:0] tl;
		logic [61:0] tc;
		r   = s;
		ta  = {1'b0, s.aq_p} + (61'd1 << 23);
		tm0 = {1'b0, s.mh_p[0]} + (65'd1 << 11);
		tm1 = {1'b0, s.mh_p[1]} + (65'd1 << 11);
		tl  = {1'b0, s.lu_p} + (65'd1 << 29);
		tc  = {1'b0, s.c_p} + (62'd1 << 15);
		case (k)
			0: begin
				r.aq_p    = 60'(s.area) * 60'(plf_pkg::KA);
				r.mh_p[0] = 64'(s.expan) * 64'(s.h[0]);
				r.mh_p[1] = 64'(s.expan) * 64'(s.h[1]);
				r.lu_p    = 64'(s.len) * 64'(f);
			end
			1: begin
				r.aq    = ta[59:24];
				r.mh[0] = tm0[63:12];
				r.mh[1] = tm1[63:12];
				r.lu    = tl[63:30];
			end
			2: begin
				r.w[0] = 53'(s.aq) + 53'(s.mh[0]);
				r.w[1] = 53'(s.aq) + 53'(s.mh[1]);
				r.c_p  = 61'(s.lu) * 61'(plf_pkg::KC);
			end
			3: begin
				r.c = tc[60:16];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	localparam int unsigned NS = plf_pkg::SQ_STAGES;

	logic                 adv;
	side_t                init;
	logic [NS-1:0]        vld_s;
	side_t                side_s [NS];
	plf_pkg::plf_sqrt_t   sq_s   [2][NS];

	assign adv = !out_valid || out_ready;
	assign pop = adv && !qstat.empty;

	always_comb begin
		init         = '0;
		init.fl.j1   = head.j1;
		init.fl.j2   = head.j2;
		init.fl.zero = head.zero;
		init.h[0]    = head.h1;
		init.h[1]    = head.h2;
		init.area    = head.area;
		init.expan   = head.expan;
		init.len     = head.len;
	end

	for (genvar k = 0; k < NS; k++) begin : g_root
		localparam int unsigned B = 2 * (NS - 1 - k);
		side_t              sp;
		plf_pkg::plf_sqrt_t rp0;
		plf_pkg::plf_sqrt_t rp1;
		logic [43:0]        x0;
		logic [43:0]        x1;
		if (k == 0) begin : g_first
			assign sp  = init;
			assign rp0 = '0;
			assign rp1 = '0;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_s[k] <= 1'b0;
				else if (adv) vld_s[k] <= pop;
			end
		end else begin : g_next
			assign sp  = side_s[k-1];
			assign rp0 = sq_s[0][k-1];
			assign rp1 = sq_s[1][k-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_s[k] <= 1'b0;
				else if (adv) vld_s[k] <= vld_s[k-1];
			end
		end
		assign x0 = {sp.h[0], 12'b0};
		assign x1 = {sp.h[1], 12'b0};
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k]   <= side_step(sp, k, luf);
				sq_s[0][k]  <= plf_pkg::sqrt_step(rp0, x0[B+1:B]);
				sq_s[1][k]  <= plf_pkg::sqrt_step(rp1, x1[B+1:B]);
			end
		end
	end

	// Post-root stages.
	logic [7:0]  pv_s;
	flags_t      fl_s23, fl_s24, fl_s25, fl_s26, fl_s27, fl_s28, fl_s29;
	logic [44:0] c_s23, c_s24, c_s25;
	logic [53:0] pl_s23  [2];
	logic [42:0] ph_s23  [2];
	logic [74:0] wsr_s24 [2];
	logic [62:0] ws_s25  [2];
	logic [63:0] p00_s26 [2];
	logic [62:0] p01_s26 [2];
	logic [44:0] p10_s26 [2];
	logic [43:0] p11_s26 [2];
	logic [63:0] p00_s27 [2];
	logic [43:0] p11_s27 [2];
	logic [64:0] mid_s27 [2];
	logic [107:0] tot_s28 [2];
	logic [47:0] q_s29   [2];
	logic [47:0] lf_s30;

	logic [75:0]  trw  [2];
	logic [108:0] trq  [2];
	logic [47:0]  qd   [2];
	logic [48:0]  a0;
	logic [48:0]  a1;
	logic [49:0]  sum;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trw[l] = {1'b0, wsr_s24[l]} + (76'd1 << 11);
			trq[l] = {1'b0, tot_s28[l]} + (109'd1 << 27);
			qd[l]  = (trq[l][108:28] > 81'(plf_pkg::CAP)) ? plf_pkg::CAP : trq[l][75:28];
		end
		a0 = fl_s29.j1 ? (fl_s29.j2 ? {1'b0, q_s29[0]} : {q_s29[0], 1'b0}) : '0;
		a1 = fl_s29.j2 ? (fl_s29.j1 ? {1'b0, q_s29[1]} : {q_s29[1], 1'b0}) : '0;
		sum = 50'(a0) + 50'(a1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s <= '0;
		else if (adv) pv_s <= {pv_s[6:0], vld_s[NS-1]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s23 <= side_s[NS-1].fl;
			c_s23  <= side_s[NS-1].c;
			fl_s24 <= fl_s23;
			c_s24  <= c_s23;
			fl_s25 <= fl_s24;
			c_s25  <= c_s24;
			fl_s26 <= fl_s25;
			fl_s27 <= fl_s26;
			fl_s28 <= fl_s27;
			fl_s29 <= fl_s28;
			for (int l = 0; l < 2; l++) begin
				pl_s23[l]  <= 54'(side_s[NS-1].w[l][31:0]) * 54'(sq_s[l][NS-1].root);
				ph_s23[l]  <= 43'(side_s[NS-1].w[l][52:32]) * 43'(sq_s[l][NS-1].root);
				wsr_s24[l] <= {ph_s23[l], 32'b0} + 75'(pl_s23[l]);
				ws_s25[l]  <= trw[l][74:12];
				p00_s26[l] <= 64'(c_s25[31:0]) * 64'(ws_s25[l][31:0]);
				p01_s26[l] <= 63'(c_s25[31:0]) * 63'(ws_s25[l][62:32]);
				p10_s26[l] <= 45'(c_s25[44:32]) * 45'(ws_s25[l][31:0]);
				p11_s26[l] <= 44'(c_s25[44:32]) * 44'(ws_s25[l][62:32]);
				p00_s27[l] <= p00_s26[l];
				p11_s27[l] <= p11_s26[l];
				mid_s27[l] <= 65'(p01_s26[l]) + 65'(p10_s26[l]);
				tot_s28[l] <= {p11_s27[l], p00_s27[l]} + {11'b0, mid_s27[l], 32'b0};
				q_s29[l]   <= qd[l];
			end
			lf_s30 <= fl_s29.zero ? '0
				: ((sum > 50'(plf_pkg::CAP)) ? plf_pkg::CAP : sum[47:0]);
		end
	end

	assign out_valid = pv_s[7];
	assign leak_flow = lf_s30;

endmodule

// File: rtl/core/pipe_leak_flow_favad.sv
// Top level of the pipe leak flow block: configuration register, front end, queue, back end.
// Depends on plf_pkg, plf_front, plf_queue and plf_back.
//
// The block evaluates the FAVAD leakage law for one pipe per item. Each item carries the
// head and elevation of both end nodes (signed Q20.12 ft), the leak area and expansion
// (Q16.16), the pipe length (Q24.8 ft) and the pipe and junction flags; the result item is
// the leakage flow in Q16.32 cfs, saturating at all ones. Negative pressure heads count as
// zero, a fixed-grade end contributes nothing and doubles the other end's half flow, and a
// non-pipe, a pipe with no leak parameters or one with no junction end gives zero. The block
// takes one item per clock cycle while the output is not stalled and returns results in
// order, through the 22-stage square-root digit pipeline followed by eight stages of
// multiply, round and saturate. A four-entry queue separates the front end from the
// arithmetic pipeline, so input items are still taken into it while a result waits, until
// it is full. The length unit factor (Q2.30, reset 1.0) is written through its own
// always-ready channel and should be changed only while no item is in flight.
module pipe_leak_flow_favad (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               is_pipe,
	input  logic               end1_is_junction,
	input  logic               end2_is_junction,
	input  logic signed [31:0] head_start,
	input  logic signed [31:0] elev_start,
	input  logic signed [31:0] head_end,
	input  logic signed [31:0] elev_end,
	input  logic        [31:0] leak_area,
	input  logic        [31:0] leak_expansion,
	input  logic        [31:0] pipe_length,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [47:0] leak_flow
);

	logic [31:0]         length_unit_factor_q;
	logic                push;
	logic                pop;
	plf_pkg::plf_entry_t entry;
	plf_pkg::plf_entry_t head;
	plf_pkg::plf_qstat_t qstat;

	// The register is always ready; a write lands at the handshake edge.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_unit_factor_q <= 32'h4000_0000;
		end else if (cfg_valid && cfg_ready) begin
			length_unit_factor_q <= cfg_data;
		end
	end

	// The front end classifies each item and pushes it straight into the queue.
	plf_front u_front (
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.is_pipe          (is_pipe),
		.end1_is_junction (end1_is_junction),
		.end2_is_junction (end2_is_junction),
		.head_start       (head_start),
		.elev_start       (elev_start),
		.head_end         (head_end),
		.elev_end         (elev_end),
		.leak_area        (leak_area),
		.leak_expansion   (leak_expansion),
		.pipe_length      (pipe_length),
		.qstat            (qstat),
		.push             (push),
		.entry            (entry)
	);

	plf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (entry),
		.pop       (pop),
		.entry_out (head),
		.qstat     (qstat)
	);

	// The back end pops an item whenever its pipeline moves and the queue holds one.
	plf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.luf       (length_unit_factor_q),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.leak_flow (leak_flow)
	);

	// The queue can never report itself full and empty at once.
	a_qstat_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue reports full and empty together");

	// An accepted item always leaves the queue occupied on the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !qstat.empty)
		else $error("accepted item did not reach the queue");

	// A pop is only issued against a non-empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from an empty queue");

endmodule
